// ----- sv/fpnr_pkg.sv -----
// ----------------------------------------------------------------------------
// fpnr_pkg
// Shared types and constants of the fixed-point Newton root unit: controller
// states, result status codes, configuration register indexes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fpnr_pkg;

  localparam int DATA_W   = 32;
  localparam int TOL_W    = 16;
  localparam int ITER_W   = 8;
  localparam int GUESS_W  = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd6;
  localparam logic [ITER_W-1:0]  ITER_RESET  = 8'd64;
  localparam logic [GUESS_W-1:0] GUESS_RESET = 31'd131072;

  // Reciprocal of three: floor(n / 3) equals (n * RECIP3) >> RECIP3_SHIFT
  // for every 32-bit unsigned n.
  localparam logic [DATA_W-1:0] RECIP3       = 32'hAAAA_AAAB;
  localparam int                RECIP3_SHIFT = 33;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_GUESS  = 2'd2;

  // Operation codes of the command input.
  localparam logic OP_SQRT = 1'b0;
  localparam logic OP_CBRT = 1'b1;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_DIV_ZERO  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_DIVQ,
    S_SCALE,
    S_DIV3,
    S_UPDATE,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic    load;       // capture operand and command, seed the estimate
    logic    mul;        // form the divisor (t or t*t)
    logic    div_q;      // start the quotient division x / divisor
    logic    diff_load;  // capture quotient minus estimate
    logic    div_3;      // capture the difference magnitude divided by three
    logic    step_load;  // capture the Newton step
    logic    update;     // apply the step and count it
    logic    fin;        // latch the final status
    status_t fin_code;
  } dp_cmd_t;

  typedef struct packed {
    logic cube;
    logic d_zero;
    logic div_busy;
    logic converged;
    logic last_step;
  } dp_status_t;

endpackage

// ----- sv/fpnr_divider.sv -----
// ----------------------------------------------------------------------------
// fpnr_divider
// Restoring divider, one quotient bit per cycle. Works on magnitudes and
// returns a signed 32-bit quotient truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module fpnr_divider #(
  parameter int NUM_W = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [NUM_W-1:0]              num,
  input  logic [fpnr_pkg::DATA_W-1:0]   den,
  input  logic                          neg,
  output logic                          busy,
  output logic [fpnr_pkg::DATA_W-1:0]   quotient
);

  localparam int DW    = fpnr_pkg::DATA_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DW:0]        rem;
  logic [NUM_W-1:0]   quo;
  logic [DW-1:0]      den_r;
  logic               neg_r;
  logic [CNT_W-1:0]   cnt;

  logic [DW:0]        rem_sh;
  logic               fits;
  logic [DW:0]        rem_next;
  logic               over;

  assign rem_sh   = {rem[DW-1:0], quo[NUM_W-1]};
  assign fits     = rem_sh >= {1'b0, den_r};
  assign rem_next = fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
  assign busy     = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
      neg_r <= neg;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  // A negative result may reach -2^31; a positive one stops at 2^31 - 1.
  always_comb begin
    if (neg_r) begin
      over = (|quo[NUM_W-1:DW]) || (quo[DW-1] && (|quo[DW-2:0]));
      quotient = over ? {1'b1, {(DW-1){1'b0}}} : (~quo[DW-1:0] + 1'b1);
    end else begin
      over = |quo[NUM_W-1:DW-1];
      quotient = over ? {1'b0, {(DW-1){1'b1}}} : quo[DW-1:0];
    end
  end

endmodule

// ----- sv/fpnr_datapath.sv -----
// ----------------------------------------------------------------------------
// fpnr_datapath
// Estimate, divisor, difference and step registers, the shared multiplier
// (squaring and division by three) and the divider of the Newton root unit.
// ----------------------------------------------------------------------------
module fpnr_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fpnr_pkg::dp_cmd_t                    cmd,
  output fpnr_pkg::dp_status_t                 sts,
  input  logic                                 command,
  input  logic signed [fpnr_pkg::DATA_W-1:0]   operand,
  input  logic [fpnr_pkg::TOL_W-1:0]           tolerance,
  input  logic [fpnr_pkg::ITER_W-1:0]          max_iterations,
  input  logic [fpnr_pkg::GUESS_W-1:0]         initial_guess,
  output logic signed [fpnr_pkg::DATA_W-1:0]   root,
  output fpnr_pkg::status_t                    status,
  output logic [fpnr_pkg::ITER_W-1:0]          steps_taken
);

  localparam int DW    = fpnr_pkg::DATA_W;
  localparam int IW    = fpnr_pkg::ITER_W;
  localparam int NUM_W = DW + FRAC_BITS;

  logic signed [DW-1:0]   x;
  logic                   cube;
  logic signed [DW-1:0]   t;
  logic signed [DW-1:0]   d;
  logic signed [DW:0]     diff;
  logic signed [DW-1:0]   step;
  logic [DW-1:0]          q3;
  logic [IW-1:0]          steps;
  fpnr_pkg::status_t      status_r;

  logic [DW-1:0]          t_mag;
  logic [DW-1:0]          mul_a;
  logic [DW-1:0]          mul_b;
  logic [2*DW-1:0]        prod;
  logic [NUM_W-1:0]       x_num;
  logic [NUM_W-1:0]       x_mag;
  logic [DW-1:0]          d_mag;
  logic [DW:0]            diff_mag;
  logic [DW:0]            diff_rnd;
  logic [DW-1:0]          half;
  logic [DW-1:0]          third;
  logic [DW-1:0]          step_mag;
  logic [IW-1:0]          cap;

  logic                   dv_start;
  logic [NUM_W-1:0]       dv_num;
  logic [DW-1:0]          dv_den;
  logic                   dv_neg;
  logic                   dv_busy;
  logic [DW-1:0]          dv_q;

  // One unsigned multiplier serves both the square of the estimate and the
  // reciprocal multiplication that divides the difference by three.
  assign t_mag    = t[DW-1] ? (~t + 1'b1) : t;
  assign mul_a    = cmd.div_3 ? diff_mag[DW-1:0] : t_mag;
  assign mul_b    = cmd.div_3 ? fpnr_pkg::RECIP3 : t_mag;
  assign prod     = (2*DW)'(mul_a) * (2*DW)'(mul_b);

  assign x_num    = {x, {FRAC_BITS{1'b0}}};
  assign x_mag    = x[DW-1] ? (~x_num + 1'b1) : x_num;
  assign d_mag    = d[DW-1] ? (~d + 1'b1) : d;
  assign diff_mag = diff[DW] ? (~diff + 1'b1) : diff;

  // Halving truncates toward zero: odd negative values round up first.
  assign diff_rnd = diff + {{DW{1'b0}}, diff[DW]};
  assign half     = diff_rnd[DW:1];

  // The third carries the sign of the difference, so it truncates toward zero.
  assign third    = diff[DW] ? (~q3 + 1'b1) : q3;

  assign step_mag = step[DW-1] ? (~step + 1'b1) : step;
  assign cap      = (max_iterations == '0) ? IW'(1) : max_iterations;

  assign dv_start = cmd.div_q;
  assign dv_num   = x_mag;
  assign dv_den   = d_mag;
  assign dv_neg   = x[DW-1] ^ d[DW-1];

  fpnr_divider #(
    .NUM_W(NUM_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .num      (dv_num),
    .den      (dv_den),
    .neg      (dv_neg),
    .busy     (dv_busy),
    .quotient (dv_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= operand;
      cube  <= command == fpnr_pkg::OP_CBRT;
      t     <= {1'b0, initial_guess};
      steps <= '0;
    end
    if (cmd.mul) begin
      d <= cube ? prod[FRAC_BITS+DW-1:FRAC_BITS] : t;
    end
    if (cmd.diff_load) begin
      diff <= {dv_q[DW-1], dv_q} - {t[DW-1], t};
    end
    if (cmd.div_3) begin
      q3 <= DW'(prod >> fpnr_pkg::RECIP3_SHIFT);
    end
    if (cmd.step_load) begin
      step <= cube ? third : half;
    end
    if (cmd.update) begin
      t     <= t + step;
      steps <= steps + 1'b1;
    end
    if (cmd.fin) begin
      status_r <= cmd.fin_code;
    end
  end

  assign sts.cube      = cube;
  assign sts.d_zero    = d == '0;
  assign sts.div_busy  = dv_busy;
  assign sts.converged = step_mag <= {{(DW-fpnr_pkg::TOL_W){1'b0}}, tolerance};
  assign sts.last_step = steps >= (cap - 1'b1);

  assign root        = t;
  assign status      = status_r;
  assign steps_taken = steps;

endmodule

// ----- sv/fpnr_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpnr_ctrl
// Sequencer of the Newton root unit: steps the datapath through divisor,
// quotient, step and update for each iteration and decides when to stop.
// ----------------------------------------------------------------------------
module fpnr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  fpnr_pkg::dp_status_t  sts,
  output fpnr_pkg::dp_cmd_t     cmd,
  output logic                  busy,
  output logic                  done
);

  fpnr_pkg::ctrl_state_t state;
  fpnr_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpnr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fpnr_pkg::S_IDLE: begin
        if (start) state_next = fpnr_pkg::S_MUL;
      end
      fpnr_pkg::S_MUL:   state_next = fpnr_pkg::S_CHECK;
      fpnr_pkg::S_CHECK: begin
        state_next = sts.d_zero ? fpnr_pkg::S_DONE : fpnr_pkg::S_DIVQ;
      end
      fpnr_pkg::S_DIVQ: begin
        if (!sts.div_busy) state_next = fpnr_pkg::S_SCALE;
      end
      fpnr_pkg::S_SCALE: begin
        state_next = sts.cube ? fpnr_pkg::S_DIV3 : fpnr_pkg::S_UPDATE;
      end
      fpnr_pkg::S_DIV3:  state_next = fpnr_pkg::S_UPDATE;
      fpnr_pkg::S_UPDATE: begin
        if (sts.converged || sts.last_step) state_next = fpnr_pkg::S_DONE;
        else state_next = fpnr_pkg::S_MUL;
      end
      fpnr_pkg::S_DONE: state_next = fpnr_pkg::S_IDLE;
      default:          state_next = fpnr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.fin_code = fpnr_pkg::ST_CONVERGED;
    busy         = state != fpnr_pkg::S_IDLE;
    done         = 1'b0;
    unique case (state)
      fpnr_pkg::S_IDLE:  cmd.load = start;
      fpnr_pkg::S_MUL:   cmd.mul = 1'b1;
      fpnr_pkg::S_CHECK: begin
        if (sts.d_zero) begin
          cmd.fin      = 1'b1;
          cmd.fin_code = fpnr_pkg::ST_DIV_ZERO;
        end else begin
          cmd.div_q = 1'b1;
        end
      end
      fpnr_pkg::S_DIVQ:  cmd.diff_load = !sts.div_busy;
      fpnr_pkg::S_SCALE: begin
        if (sts.cube) cmd.div_3 = 1'b1;
        else cmd.step_load = 1'b1;
      end
      fpnr_pkg::S_DIV3:  cmd.step_load = 1'b1;
      fpnr_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        // Convergence on the last allowed step still counts as converged.
        if (sts.converged) begin
          cmd.fin      = 1'b1;
          cmd.fin_code = fpnr_pkg::ST_CONVERGED;
        end else if (sts.last_step) begin
          cmd.fin      = 1'b1;
          cmd.fin_code = fpnr_pkg::ST_LIMIT;
        end
      end
      fpnr_pkg::S_DONE:  done = 1'b1;
      default:           done = 1'b0;
    endcase
  end

endmodule

// ----- sv/fixed_point_newton_root_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_point_newton_root_unit
// Newton-Raphson square and cube root of a signed fixed-point operand.
// ----------------------------------------------------------------------------
// The unit takes one operand at a time: a transfer happens on a clock edge
// with start high and busy low, and busy then stays high until the result
// has been shown. The result (root, status, steps_taken) is on its ports
// for exactly one cycle with done high; the receiver cannot stall it, so it
// must take it in that cycle. Each Newton iteration runs its quotient on a
// restoring divider that produces one quotient bit per cycle over
// N = 32 + FRAC_BITS bits. A cube-root iteration adds a state, dividing the
// difference by three with a reciprocal multiplication on the squaring
// multiplier. After the transfer, busy stays high through every iteration
// and while the result is shown; a zero divisor ends the item before its
// division starts. The next transfer can happen at the end of the first
// cycle with busy low.
// The configuration registers (tolerance, max_iterations, initial_guess) are
// written through cfg_write, cfg_index and cfg_data and take effect for the
// next item; they should only be written while busy is low. A write to an
// index beyond the list is ignored.

module fixed_point_newton_root_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command,
  input  logic signed [fpnr_pkg::DATA_W-1:0]   operand,
  output logic                                 done,
  output logic signed [fpnr_pkg::DATA_W-1:0]   root,
  output logic [1:0]                           status,
  output logic [fpnr_pkg::ITER_W-1:0]          steps_taken,
  input  logic                                 cfg_write,
  input  logic [fpnr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fpnr_pkg::GUESS_W-1:0]         cfg_data
);

  logic [fpnr_pkg::TOL_W-1:0]   tolerance;
  logic [fpnr_pkg::ITER_W-1:0]  max_iterations;
  logic [fpnr_pkg::GUESS_W-1:0] initial_guess;

  fpnr_pkg::dp_cmd_t    cmd;
  fpnr_pkg::dp_status_t sts;
  fpnr_pkg::status_t    status_code;

  // Configuration registers. Unknown indexes fall through the decoder.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= fpnr_pkg::TOL_RESET;
      max_iterations <= fpnr_pkg::ITER_RESET;
      initial_guess  <= fpnr_pkg::GUESS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fpnr_pkg::CFG_TOLERANCE:
          tolerance <= cfg_data[fpnr_pkg::TOL_W-1:0];
        fpnr_pkg::CFG_MAX_ITERATIONS:
          max_iterations <= cfg_data[fpnr_pkg::ITER_W-1:0];
        fpnr_pkg::CFG_INITIAL_GUESS:
          initial_guess <= cfg_data;
        default: ;
      endcase
    end
  end

  // The controller sequences one iteration at a time and the datapath holds
  // every value that carries from one iteration to the next.
  fpnr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  fpnr_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .command        (command),
    .operand        (operand),
    .tolerance      (tolerance),
    .max_iterations (max_iterations),
    .initial_guess  (initial_guess),
    .root           (root),
    .status         (status_code),
    .steps_taken    (steps_taken)
  );

  assign status = status_code;

  // A transfer always makes the unit busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the unit busy");

  // The result strobe lasts one cycle and returns the unit to idle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

  // Giving up on the iteration cap means the full cap of steps was taken.
  a_limit_steps: assert property (@(posedge clk) disable iff (rst)
    (done && status == fpnr_pkg::ST_LIMIT) |->
      (steps_taken == max_iterations ||
       (max_iterations == '0 && steps_taken == fpnr_pkg::ITER_W'(1))))
    else $error("limit status with a step count below the cap");

  // A zero divisor is caught before any step of that iteration is applied,
  // so the count never exceeds the cap.
  a_steps_cap: assert property (@(posedge clk) disable iff (rst)
    (done && max_iterations != '0) |-> steps_taken <= max_iterations)
    else $error("more steps taken than the cap allows");

endmodule
